// ===== design/nis_pkg.sv =====
// Shared types, widths and helpers for the Newton-Cotes integration block.
// Used by nis_accum, nis_scale and numeric_integration_weighted_sum.
package nis_pkg;

	localparam int SAMPLE_W  = 32;
	localparam int STEP_W    = 32;
	localparam int ACC_W     = 48;
	localparam int IC_W      = 11;
	localparam int MODE_W    = 2;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CHUNK_W   = 16;
	localparam int N_CHUNKS  = ACC_W / CHUNK_W;
	localparam int BM_W      = STEP_W + 2;
	localparam int PROD_W    = ACC_W + BM_W;
	localparam int QUOT_W    = PROD_W - 16;

	// divide by 3 one 16-bit digit at a time
	localparam int DIV_DIGITS = (QUOT_W + CHUNK_W - 1) / CHUNK_W;
	localparam int DIV_W      = DIV_DIGITS * CHUNK_W;
	localparam int RECIP_W    = CHUNK_W + 2;
	localparam int RECIP_SH   = CHUNK_W + 3;
	localparam logic [RECIP_W-1:0] RECIP3 = 18'h2AAAB;   // ceil(2^19 / 3)

	localparam int MAX_INTERVALS_DEF = 1024;

	localparam logic [MODE_W-1:0] MODE_TRAP   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SIMP3  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SIMP8  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_RULE_MODE      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_WIDTH     = 2'd2;

	localparam logic [IC_W-1:0]   RST_INTERVAL_COUNT = 11'd1;
	localparam logic [STEP_W-1:0] RST_STEP_WIDTH     = 32'h0001_0000;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	// request from the accumulator side to the scaling sequencer
	typedef struct packed {
		logic              start;
		logic [MODE_W-1:0] mode;
		logic              err;
		logic              neg;
		logic [ACC_W-1:0]  mag;
	} nis_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [ACC_W-1:0] value;
		logic             err;
	} nis_stat_t;

	// residue mod 3 by summing base-4 digits (4 = 1 mod 3)
	function automatic logic [1:0] mod3_11(input logic [IC_W-1:0] v);
		logic [4:0] s1;
		logic [2:0] s2;
		logic [1:0] r;
		s1 = 5'(v[1:0]) + 5'(v[3:2]) + 5'(v[5:4]) + 5'(v[7:6]) + 5'(v[9:8]) + 5'(v[10]);
		s2 = 3'(s1[1:0]) + 3'(s1[3:2]) + 3'(s1[4]);
		case (s2)
			3'd0, 3'd3, 3'd6: r = 2'd0;
			3'd1, 3'd4, 3'd7: r = 2'd1;
			3'd2, 3'd5:       r = 2'd2;
			default:          r = 2'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== design/nis_accum.sv =====
// Weighted-sample accumulator: sample index, rule weights, saturating sum.
// Depends on nis_pkg.
module nis_accum #(
	parameter int MAX_INTERVALS = nis_pkg::MAX_INTERVALS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               fire,
	input  logic signed [nis_pkg::SAMPLE_W-1:0] sample_value,
	input  logic [nis_pkg::MODE_W-1:0]         rule_mode,
	input  logic [nis_pkg::IC_W-1:0]           interval_count,
	output logic                               last,
	output logic                               err,
	output logic                               neg,
	output logic [nis_pkg::ACC_W-1:0]          mag
);

	localparam int IW = $clog2(MAX_INTERVALS + 1);
	localparam int CW = (IW > nis_pkg::IC_W) ? IW : nis_pkg::IC_W;

	logic signed [nis_pkg::ACC_W-1:0] acc_q;
	logic [IW-1:0]                    idx_q;
	logic [1:0]                       phase_q;   // idx_q mod 3

	logic [nis_pkg::IC_W-1:0]         n_eff;
	logic [2:0]                       weight;
	logic signed [34:0]               y_ext;
	logic signed [34:0]               wy;
	logic signed [49:0]               sum;
	logic signed [nis_pkg::ACC_W-1:0] sum_sat;

	always_comb begin
		if (interval_count == '0) begin
			n_eff = nis_pkg::IC_W'(1);
		end else if (int'(interval_count) > MAX_INTERVALS) begin
			n_eff = nis_pkg::IC_W'(MAX_INTERVALS);
		end else begin
			n_eff = interval_count;
		end
	end

	assign last = CW'(idx_q) >= CW'(n_eff);

	assign err = (rule_mode == nis_pkg::MODE_UNUSED) ||
	             (rule_mode == nis_pkg::MODE_SIMP3 && n_eff[0]) ||
	             (rule_mode == nis_pkg::MODE_SIMP8 && nis_pkg::mod3_11(n_eff) != 2'd0);

	always_comb begin
		if (idx_q == '0 || last) begin
			weight = 3'd1;
		end else begin
			case (rule_mode)
				nis_pkg::MODE_SIMP3: weight = idx_q[0] ? 3'd4 : 3'd2;
				nis_pkg::MODE_SIMP8: weight = (phase_q == 2'd0) ? 3'd2 : 3'd3;
				default:             weight = 3'd2;
			endcase
		end
	end

	assign y_ext = {{3{sample_value[31]}}, sample_value};

	always_comb begin
		case (weight)
			3'd2:    wy = y_ext <<< 1;
			3'd3:    wy = y_ext + (y_ext <<< 1);
			3'd4:    wy = y_ext <<< 2;
			default: wy = y_ext;
		endcase
	end

	assign sum = {{2{acc_q[47]}}, acc_q} + {{15{wy[34]}}, wy};

	always_comb begin
		if (sum[49:47] == 3'b000 || sum[49:47] == 3'b111) begin
			sum_sat = sum[47:0];
		end else if (sum[49]) begin
			sum_sat = nis_pkg::ACC_MIN;
		end else begin
			sum_sat = nis_pkg::ACC_MAX;
		end
	end

	assign neg = sum_sat[47];
	assign mag = neg ? nis_pkg::ACC_W'(-sum_sat) : nis_pkg::ACC_W'(sum_sat);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			idx_q   <= '0;
			phase_q <= '0;
		end else if (fire) begin
			if (last) begin
				acc_q   <= '0;
				idx_q   <= '0;
				phase_q <= '0;
			end else begin
				acc_q   <= sum_sat;
				idx_q   <= idx_q + IW'(1);
				phase_q <= (phase_q == 2'd2) ? 2'd0 : phase_q + 2'd1;
			end
		end
	end

endmodule

// ===== design/nis_scale.sv =====
// Scaling sequencer: magnitude times h (3h for Simpson 3/8, 16-bit chunks), fixed shift,
// divide by 3 one 16-bit digit per step for Simpson 1/3, then sign and saturation. Uses nis_pkg.
module nis_scale (
	input  logic                        clk,
	input  logic                        arst_n,
	input  nis_pkg::nis_req_t           req,
	input  logic [nis_pkg::STEP_W-1:0]  step_width,
	input  logic                        take,
	output nis_pkg::nis_stat_t          stat
);

	typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_SHIFT, ST_DIV, ST_SAT, ST_HOLD} state_t;

	localparam int CNT_W = $clog2(nis_pkg::DIV_DIGITS);

	state_t                         state_q;
	logic [CNT_W-1:0]               cnt_q;
	logic [nis_pkg::MODE_W-1:0]     mode_q;
	logic                           neg_q;
	logic                           err_q;
	logic [nis_pkg::ACC_W-1:0]      mag_q;
	logic [nis_pkg::BM_W-1:0]       bm_q;
	logic [nis_pkg::PROD_W-1:0]     prod_q;
	logic [nis_pkg::DIV_W-1:0]      quot_q;
	logic [1:0]                     rem_q;
	logic [nis_pkg::ACC_W-1:0]      value_q;

	logic [nis_pkg::CHUNK_W+nis_pkg::BM_W-1:0] chunk_prod;
	logic [nis_pkg::RECIP_W-1:0]    cur;
	logic [2*nis_pkg::RECIP_W-1:0]  recip_prod;
	logic [nis_pkg::CHUNK_W-1:0]    qdigit;
	logic [nis_pkg::RECIP_W-1:0]    qdigit_x3;
	logic                           over;

	assign chunk_prod = mag_q[nis_pkg::ACC_W-1 -: nis_pkg::CHUNK_W] * bm_q;
	// remainder and next digit; x/3 = (x * ceil(2^19/3)) >> 19, exact for x below 2^19
	assign cur        = {rem_q, quot_q[nis_pkg::DIV_W-1 -: nis_pkg::CHUNK_W]};
	assign recip_prod = cur * nis_pkg::RECIP3;
	assign qdigit     = recip_prod[nis_pkg::RECIP_SH +: nis_pkg::CHUNK_W];
	assign qdigit_x3  = {2'b0, qdigit} + {1'b0, qdigit, 1'b0};
	assign over       = |quot_q[nis_pkg::DIV_W-1:nis_pkg::ACC_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req.start) begin
						mode_q  <= req.mode;
						neg_q   <= req.neg;
						err_q   <= req.err;
						mag_q   <= req.mag;
						bm_q    <= (req.mode == nis_pkg::MODE_SIMP8) ?
						           {2'b0, step_width} + {1'b0, step_width, 1'b0} :
						           {2'b0, step_width};
						prod_q  <= '0;
						value_q <= '0;
						cnt_q   <= '0;
						state_q <= req.err ? ST_HOLD : ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q <= {prod_q[nis_pkg::PROD_W-nis_pkg::CHUNK_W-1:0],
					           {nis_pkg::CHUNK_W{1'b0}}} +
					          nis_pkg::PROD_W'(chunk_prod);
					mag_q  <= {mag_q[nis_pkg::ACC_W-nis_pkg::CHUNK_W-1:0],
					           {nis_pkg::CHUNK_W{1'b0}}};
					if (cnt_q == CNT_W'(nis_pkg::N_CHUNKS - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_SHIFT;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_SHIFT: begin
					// Q50.32 down to Q50.16 plus the /2 or /8 of the rule
					case (mode_q)
						nis_pkg::MODE_SIMP3: quot_q <= nis_pkg::DIV_W'(prod_q >> 16);
						nis_pkg::MODE_SIMP8: quot_q <= nis_pkg::DIV_W'(prod_q >> 19);
						default:             quot_q <= nis_pkg::DIV_W'(prod_q >> 17);
					endcase
					rem_q   <= '0;
					state_q <= (mode_q == nis_pkg::MODE_SIMP3) ? ST_DIV : ST_SAT;
				end
				ST_DIV: begin
					quot_q <= {quot_q[nis_pkg::DIV_W-nis_pkg::CHUNK_W-1:0], qdigit};
					rem_q  <= 2'(cur - qdigit_x3);
					if (cnt_q == CNT_W'(nis_pkg::DIV_DIGITS - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_SAT;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_SAT: begin
					if (neg_q) begin
						value_q <= over ? nis_pkg::ACC_MIN :
						           nis_pkg::ACC_W'(-quot_q[nis_pkg::ACC_W-1:0]);
					end else begin
						value_q <= over ? nis_pkg::ACC_MAX : quot_q[nis_pkg::ACC_W-1:0];
					end
					state_q <= ST_HOLD;
				end
				ST_HOLD: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign stat.busy  = state_q != ST_IDLE;
	assign stat.done  = state_q == ST_HOLD;
	assign stat.value = value_q;
	assign stat.err   = err_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> state_q == ST_IDLE)
		else $error("scale start while busy");

	a_err_fast: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && req.start && req.err) |=> state_q == ST_HOLD)
		else $error("error transaction did not skip the datapath");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HOLD && err_q) |-> value_q == '0)
		else $error("error result not zero");

	a_div_mode: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> mode_q == nis_pkg::MODE_SIMP3)
		else $error("divide step outside Simpson 1/3");

endmodule

// ===== design/numeric_integration_weighted_sum.sv =====
// Newton-Cotes integration (trapezoid, Simpson 1/3, Simpson 3/8) over a sample stream.
// Non-final sample: accepted, no result. Final sample: result_valid after multiply, shift,
// divide (Simpson 1/3) and saturate steps (none on a rule error); sample_ready low meanwhile,
// and longer while a previous result still waits in the output register.
// Cost set by the 3-step 16-bit chunk multiplier and the 5-step divide-by-3 digit loop.
// Async reset clears the sum and index and restores the register reset values.
// Depends on nis_pkg, nis_accum, nis_scale.
module numeric_integration_weighted_sum #(
	parameter int MAX_INTERVALS = nis_pkg::MAX_INTERVALS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [nis_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [nis_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                sample_valid,
	output logic                                sample_ready,
	input  logic signed [nis_pkg::SAMPLE_W-1:0] sample_value,
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic signed [nis_pkg::ACC_W-1:0]    integral_value,
	output logic                                rule_error
);

	logic [nis_pkg::MODE_W-1:0] rule_mode_q;
	logic [nis_pkg::IC_W-1:0]   interval_count_q;
	logic [nis_pkg::STEP_W-1:0] step_width_q;

	logic                       out_valid_q;
	logic [nis_pkg::ACC_W-1:0]  integral_q;
	logic                       rule_error_q;

	logic                       fire;
	logic                       last;
	logic                       err;
	logic                       neg;
	logic [nis_pkg::ACC_W-1:0]  mag;
	logic                       take;
	nis_pkg::nis_req_t          req;
	nis_pkg::nis_stat_t         stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_mode_q      <= nis_pkg::MODE_TRAP;
			interval_count_q <= nis_pkg::RST_INTERVAL_COUNT;
			step_width_q     <= nis_pkg::RST_STEP_WIDTH;
		end else if (cfg_write) begin
			case (cfg_index)
				nis_pkg::REG_RULE_MODE:      rule_mode_q      <= cfg_data[nis_pkg::MODE_W-1:0];
				nis_pkg::REG_INTERVAL_COUNT: interval_count_q <= cfg_data[nis_pkg::IC_W-1:0];
				nis_pkg::REG_STEP_WIDTH:     step_width_q     <= cfg_data[nis_pkg::STEP_W-1:0];
				default: ;
			endcase
		end
	end

	assign sample_ready = !stat.busy;
	assign fire         = sample_valid && sample_ready;

	nis_accum #(.MAX_INTERVALS(MAX_INTERVALS)) u_accum (
		.clk            (clk),
		.arst_n         (arst_n),
		.fire           (fire),
		.sample_value   (sample_value),
		.rule_mode      (rule_mode_q),
		.interval_count (interval_count_q),
		.last           (last),
		.err            (err),
		.neg            (neg),
		.mag            (mag)
	);

	always_comb begin
		req.start = fire && last;
		req.mode  = rule_mode_q;
		req.err   = err;
		req.neg   = neg;
		req.mag   = mag;
	end

	// output register frees the sequencer once its result is moved out
	assign take = !out_valid_q || result_ready;

	nis_scale u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.step_width (step_width_q),
		.take       (take),
		.stat       (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= stat.done;
		end
	end

	always_ff @(posedge clk) begin
		if (take && stat.done) begin
			integral_q   <= stat.value;
			rule_error_q <= stat.err;
		end
	end

	assign result_valid   = out_valid_q;
	assign integral_value = integral_q;
	assign rule_error     = rule_error_q;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for numeric_integration_weighted_sum: sample streams under all rules,
// register settings and random handshake stalls, each integral checked by an in-bench model.
// Depends on nis_pkg and the design sources under design/.
module testbench;

	localparam int CLK_HALF     = 10;
	localparam int QUIET_CYCLES = 90;     // longest final-sample latency plus margin
	localparam int TAIL_CYCLES  = 100;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int ITEM_TARGET  = 1250;
	localparam int MIN_STREAMS  = 20;
	localparam int IDLE_PCT     = 24;

	typedef enum logic [1:0] {OP_SAMPLE, OP_REG_WRITE, OP_DRAIN} op_kind_t;

	typedef struct {
		op_kind_t                       kind;
		logic [nis_pkg::CFG_IDX_W-1:0]  index;
		logic [nis_pkg::CFG_W-1:0]      data;
	} op_t;

	typedef struct {
		logic signed [nis_pkg::ACC_W-1:0] value;
		logic                             err;
	} integral_t;

	logic                                clk          = 1'b0;
	logic                                arst_n       = 1'b0;
	logic                                cfg_write    = 1'b0;
	logic [nis_pkg::CFG_IDX_W-1:0]       cfg_index    = '0;
	logic [nis_pkg::CFG_W-1:0]           cfg_data     = '0;
	logic                                sample_valid = 1'b0;
	logic                                sample_ready;
	logic signed [nis_pkg::SAMPLE_W-1:0] sample_value = '0;
	logic                                result_valid;
	logic                                result_ready = 1'b0;
	logic signed [nis_pkg::ACC_W-1:0]    integral_value;
	logic                                rule_error;

	op_t       op_queue[$];
	integral_t pending_integrals[$];

	// integrator model state
	logic [nis_pkg::MODE_W-1:0]       m_mode;
	logic [nis_pkg::IC_W-1:0]         m_count;
	logic [nis_pkg::STEP_W-1:0]       m_step;
	logic signed [nis_pkg::ACC_W-1:0] m_sum;
	logic [nis_pkg::IC_W-1:0]         m_index;

	logic [nis_pkg::IC_W-1:0] plan_count;
	int items_queued      = 0;
	int streams_queued    = 0;
	int samples_sent      = 0;
	int writes_done       = 0;
	int integrals_checked = 0;
	int error_count       = 0;
	int cycle_count       = 0;
	int quiet             = 0;
	logic steady;

	assign steady = (cycle_count % 6000) >= 4500;

	numeric_integration_weighted_sum u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.sample_valid   (sample_valid),
		.sample_ready   (sample_ready),
		.sample_value   (sample_value),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.integral_value (integral_value),
		.rule_error     (rule_error)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Adds one sample with its rule weight; on the last one queues the scaled sum, or zero on a rule error.
	function automatic void integrate_sample(input logic signed [nis_pkg::SAMPLE_W-1:0] y);
		logic [nis_pkg::IC_W-1:0]           n;
		logic                               is_last;
		logic                               err;
		logic                               neg;
		logic signed [nis_pkg::ACC_W+1:0]   term;
		logic signed [nis_pkg::ACC_W+1:0]   total;
		logic [nis_pkg::ACC_W-1:0]          mag;
		logic [nis_pkg::BM_W-1:0]           bm;
		logic [nis_pkg::PROD_W-1:0]         prod;
		integral_t                          res;
		if (m_count == '0)
			n = nis_pkg::IC_W'(1);
		else if (m_count > nis_pkg::IC_W'(nis_pkg::MAX_INTERVALS_DEF))
			n = nis_pkg::IC_W'(nis_pkg::MAX_INTERVALS_DEF);
		else
			n = m_count;
		is_last = m_index >= n;
		term = {{(nis_pkg::ACC_W + 2 - nis_pkg::SAMPLE_W){y[nis_pkg::SAMPLE_W-1]}}, y};
		if (m_index != '0 && !is_last) begin
			case (m_mode)
				nis_pkg::MODE_SIMP3: term = m_index[0] ? (term <<< 2) : (term <<< 1);
				nis_pkg::MODE_SIMP8:
					term = (m_index % 3 == 0) ? (term <<< 1) : (term + (term <<< 1));
				default:             term = term <<< 1;
			endcase
		end
		total = {{2{m_sum[nis_pkg::ACC_W-1]}}, m_sum} + term;
		if (total[nis_pkg::ACC_W+1:nis_pkg::ACC_W-1] == 3'b000 ||
			total[nis_pkg::ACC_W+1:nis_pkg::ACC_W-1] == 3'b111)
			m_sum = total[nis_pkg::ACC_W-1:0];
		else
			m_sum = total[nis_pkg::ACC_W+1] ? nis_pkg::ACC_MIN : nis_pkg::ACC_MAX;
		if (!is_last) begin
			m_index = m_index + 1'b1;
			return;
		end
		err = (m_mode == nis_pkg::MODE_UNUSED) || (m_mode == nis_pkg::MODE_SIMP3 && n[0]) ||
			(m_mode == nis_pkg::MODE_SIMP8 && (n % 3) != 0);
		res.value = '0;
		res.err = err;
		if (!err) begin
			neg = m_sum[nis_pkg::ACC_W-1];
			mag = neg ? (~m_sum + 1'b1) : m_sum;
			if (m_mode == nis_pkg::MODE_SIMP8)
				bm = nis_pkg::BM_W'(m_step) + (nis_pkg::BM_W'(m_step) << 1);
			else
				bm = nis_pkg::BM_W'(m_step);
			prod = nis_pkg::PROD_W'(mag) * nis_pkg::PROD_W'(bm);
			case (m_mode)
				nis_pkg::MODE_TRAP:  prod = prod >> 17;
				nis_pkg::MODE_SIMP3: prod = (prod >> 16) / 3;
				default:             prod = prod >> 19;
			endcase
			// anything at or above 2^47 clips for either sign
			if (|prod[nis_pkg::PROD_W-1:nis_pkg::ACC_W-1])
				res.value = neg ? nis_pkg::ACC_MIN : nis_pkg::ACC_MAX;
			else
				res.value = neg ? -$signed(prod[nis_pkg::ACC_W-1:0]) :
					$signed(prod[nis_pkg::ACC_W-1:0]);
		end
		pending_integrals.push_back(res);
		m_sum = '0;
		m_index = '0;
	endfunction

	task automatic queue_sample(input logic [nis_pkg::SAMPLE_W-1:0] v);
		op_queue.push_back('{OP_SAMPLE, '0, nis_pkg::CFG_W'(v)});
		items_queued++;
	endtask

	task automatic queue_reg(input logic [nis_pkg::CFG_IDX_W-1:0] idx,
		input logic [nis_pkg::CFG_W-1:0] v);
		op_queue.push_back('{OP_REG_WRITE, idx, v});
		if (idx == nis_pkg::REG_INTERVAL_COUNT)
			plan_count = v[nis_pkg::IC_W-1:0];
	endtask

	task automatic queue_drain();
		op_queue.push_back('{OP_DRAIN, '0, '0});
	endtask

	function automatic logic [nis_pkg::SAMPLE_W-1:0] rand_sample();
		logic [nis_pkg::SAMPLE_W-1:0] r;
		r = $urandom;
		case ($urandom_range(5))
			0: r = r[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
			1: r = {{12{r[31]}}, r[19:0]};
			2: r = {{16{r[31]}}, r[15:0]};
			default: ;
		endcase
		return r;
	endfunction

	// one complete integral at the interval count the stream will see
	task automatic queue_stream();
		int len;
		if (plan_count == '0)
			len = 2;
		else if (plan_count > nis_pkg::IC_W'(nis_pkg::MAX_INTERVALS_DEF))
			len = nis_pkg::MAX_INTERVALS_DEF + 1;
		else
			len = plan_count + 1;
		repeat (len) queue_sample(rand_sample());
		streams_queued++;
	endtask

	always @(posedge clk or negedge arst_n) begin : driver
		logic                          fire;
		logic                          nxt_valid;
		logic                          nxt_write;
		logic [nis_pkg::SAMPLE_W-1:0]  nxt_value;
		logic [nis_pkg::CFG_IDX_W-1:0] nxt_index;
		logic [nis_pkg::CFG_W-1:0]     nxt_data;
		op_t                           head;
		if (!arst_n) begin
			sample_valid <= 1'b0;
			sample_value <= '0;
			cfg_write <= 1'b0;
			cfg_index <= '0;
			cfg_data <= '0;
			m_mode = nis_pkg::MODE_TRAP;
			m_count = nis_pkg::RST_INTERVAL_COUNT;
			m_step = nis_pkg::RST_STEP_WIDTH;
			m_sum = '0;
			m_index = '0;
			quiet = 0;
		end else begin
			fire = sample_valid && sample_ready;
			if (cfg_write) begin
				writes_done++;
				case (cfg_index)
					nis_pkg::REG_RULE_MODE:      m_mode = cfg_data[nis_pkg::MODE_W-1:0];
					nis_pkg::REG_INTERVAL_COUNT: m_count = cfg_data[nis_pkg::IC_W-1:0];
					nis_pkg::REG_STEP_WIDTH:     m_step = cfg_data[nis_pkg::STEP_W-1:0];
					default: ;
				endcase
			end
			if (fire) begin
				integrate_sample(sample_value);
				samples_sent++;
				quiet = 0;
			end else if (quiet < QUIET_CYCLES) begin
				quiet++;
			end
			nxt_valid = sample_valid && !fire;
			nxt_value = sample_value;
			nxt_write = 1'b0;
			nxt_index = cfg_index;
			nxt_data = cfg_data;
			if (!nxt_valid && op_queue.size() != 0) begin
				head = op_queue[0];
				case (head.kind)
					OP_SAMPLE: begin
						if (steady || $urandom_range(99) >= IDLE_PCT) begin
							nxt_valid = 1'b1;
							nxt_value = head.data[nis_pkg::SAMPLE_W-1:0];
							void'(op_queue.pop_front());
						end
					end
					OP_REG_WRITE: begin
						// registers change only with nothing in flight
						if (pending_integrals.size() == 0 && quiet >= QUIET_CYCLES) begin
							nxt_write = 1'b1;
							nxt_index = head.index;
							nxt_data = head.data;
							void'(op_queue.pop_front());
						end
					end
					default: begin
						if (pending_integrals.size() == 0)
							void'(op_queue.pop_front());
					end
				endcase
			end
			sample_valid <= nxt_valid;
			sample_value <= nxt_value;
			cfg_write <= nxt_write;
			cfg_index <= nxt_index;
			cfg_data <= nxt_data;
		end
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		integral_t want;
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				integrals_checked++;
				if (pending_integrals.size() == 0) begin
					$error("unexpected transaction: integral_value %h rule_error %b",
						integral_value, rule_error);
					error_count++;
				end else begin
					want = pending_integrals.pop_front();
					if (integral_value !== want.value) begin
						$error("integral_value: expected %h, got %h", want.value, integral_value);
						error_count++;
					end
					if (rule_error !== want.err) begin
						$error("rule_error: expected %b, got %b", want.err, rule_error);
						error_count++;
					end
				end
			end
			result_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	initial begin : stimulus
		logic [nis_pkg::MODE_W-1:0] mode;
		logic [nis_pkg::IC_W-1:0]   cnt;
		logic [nis_pkg::STEP_W-1:0] step;
		plan_count = nis_pkg::RST_INTERVAL_COUNT;

		// reset values: trapezoid, one interval, unit step, full-scale samples
		queue_sample(32'h7FFF_FFFF);
		queue_sample(32'h8000_0000);
		// widest step drives the positive result close to, but still under, its clip
		queue_reg(nis_pkg::REG_STEP_WIDTH, 32'hFFFF_FFFF);
		queue_sample(32'h7FFF_FFFF);
		queue_sample(32'h7FFF_FFFF);
		// with two intervals the negative one is driven into its clip
		queue_reg(nis_pkg::REG_INTERVAL_COUNT, 32'd2);
		repeat (3) queue_sample(32'h8000_0000);
		queue_reg(nis_pkg::REG_RULE_MODE, nis_pkg::CFG_W'(nis_pkg::MODE_SIMP3));
		queue_reg(nis_pkg::REG_STEP_WIDTH, 32'h0000_8000);
		queue_sample(32'h0001_0000);
		queue_sample(32'hFFFE_0000);
		queue_sample(32'h0003_0000);
		// odd interval count under Simpson 1/3
		queue_reg(nis_pkg::REG_INTERVAL_COUNT, 32'd1);
		queue_sample(32'h0002_0000);
		queue_sample(32'hFFFF_0000);
		queue_reg(nis_pkg::REG_RULE_MODE, nis_pkg::CFG_W'(nis_pkg::MODE_SIMP8));
		queue_reg(nis_pkg::REG_INTERVAL_COUNT, 32'd3);
		queue_reg(nis_pkg::REG_STEP_WIDTH, 32'h0000_5555);
		queue_sample(32'h0001_0000);
		queue_sample(32'h0004_8000);
		queue_sample(32'hFFF0_0001);
		queue_sample(32'h7FFF_FFFF);
		// interval count not a multiple of three
		queue_reg(nis_pkg::REG_INTERVAL_COUNT, 32'd1);
		queue_sample(32'h1234_5678);
		queue_sample(32'h0000_0001);
		// rule code with no rule behind it
		queue_reg(nis_pkg::REG_RULE_MODE, nis_pkg::CFG_W'(nis_pkg::MODE_UNUSED));
		queue_sample(32'h0001_0000);
		queue_sample(32'h0001_0000);
		// zero count runs as one interval; zero step
		queue_reg(nis_pkg::REG_RULE_MODE, nis_pkg::CFG_W'(nis_pkg::MODE_TRAP));
		queue_reg(nis_pkg::REG_INTERVAL_COUNT, 32'd0);
		queue_reg(nis_pkg::REG_STEP_WIDTH, 32'd0);
		queue_sample(32'h7FFF_FFFF);
		queue_sample(32'h8000_0000);
		// count shrinks below the index mid-stream: next sample closes the integral
		queue_reg(nis_pkg::REG_INTERVAL_COUNT, 32'd4);
		queue_reg(nis_pkg::REG_STEP_WIDTH, 32'h0001_0000);
		queue_sample(32'h0003_0000);
		queue_sample(32'hFFFF_8000);
		queue_reg(nis_pkg::REG_INTERVAL_COUNT, 32'd1);
		queue_sample(32'h0000_4000);
		queue_drain();

		// one full-length stream, count above the cap
		queue_reg(nis_pkg::REG_RULE_MODE, nis_pkg::CFG_W'(nis_pkg::MODE_SIMP3));
		queue_reg(nis_pkg::REG_INTERVAL_COUNT, 32'h7FF);
		queue_reg(nis_pkg::REG_STEP_WIDTH, $urandom);
		queue_stream();

		mode = nis_pkg::MODE_SIMP3;
		while (items_queued < ITEM_TARGET || streams_queued < MIN_STREAMS) begin
			if ($urandom_range(3) != 0) begin
				case ($urandom_range(9))
					0, 1, 2: mode = nis_pkg::MODE_TRAP;
					3, 4, 5: mode = nis_pkg::MODE_SIMP3;
					6, 7, 8: mode = nis_pkg::MODE_SIMP8;
					default: mode = nis_pkg::MODE_UNUSED;
				endcase
				queue_reg(nis_pkg::REG_RULE_MODE, nis_pkg::CFG_W'(mode));
			end
			if ($urandom_range(3) != 0) begin
				if ($urandom_range(4) == 0)
					cnt = nis_pkg::IC_W'($urandom_range(0, 13));
				else if (mode == nis_pkg::MODE_SIMP3)
					cnt = nis_pkg::IC_W'(2 * $urandom_range(1, 6));
				else if (mode == nis_pkg::MODE_SIMP8)
					cnt = nis_pkg::IC_W'(3 * $urandom_range(1, 4));
				else
					cnt = nis_pkg::IC_W'($urandom_range(1, 12));
				if ($urandom_range(15) == 0)
					cnt = nis_pkg::IC_W'($urandom_range(13, 60));
				queue_reg(nis_pkg::REG_INTERVAL_COUNT, nis_pkg::CFG_W'(cnt));
			end
			if ($urandom_range(2) != 0) begin
				case ($urandom_range(3))
					0: step = $urandom;
					1: step = $urandom_range(0, 32'h0004_0000);
					2: step = nis_pkg::RST_STEP_WIDTH;
					default: step = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
				endcase
				queue_reg(nis_pkg::REG_STEP_WIDTH, step);
			end
			repeat ($urandom_range(1, 4)) begin
				queue_stream();
				if ($urandom_range(7) == 0)
					queue_drain();
			end
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (op_queue.size() != 0 || sample_valid || cfg_write)
			@(posedge clk);
		while (pending_integrals.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_integrals.size() != 0) begin
			$error("%0d integrals never arrived", pending_integrals.size());
			error_count++;
		end

		$display("Streamed %0d samples over %0d register writes; %0d integrals compared.",
			samples_sent, writes_done, integrals_checked);
		$display("Rules: trapezoid, Simpson 1/3, Simpson 3/8 and the unused code, with stalls.");
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
